FILE: rtl/pfd_pkg.sv
package pfd_pkg;

	localparam int unsigned OFFSET_W = 34;

	localparam logic [2:0] KIND_HEARTBEAT = 3'd0;
	localparam logic [2:0] KIND_TRANSFER  = 3'd1;
	localparam logic [2:0] KIND_LOGIN     = 3'd2;
	localparam logic [2:0] KIND_CHAT      = 3'd3;
	localparam logic [2:0] KIND_CHECK     = 3'd4;
	localparam logic [2:0] KIND_UNKNOWN   = 3'd5;

	localparam logic [15:0] PROP_CHAT  = 16'd1;
	localparam logic [15:0] PROP_LOGIN = 16'd10;
	localparam logic [15:0] PROP_CHECK = 16'd12;

	localparam logic [7:0] FLAG_HEARTBEAT_BIT = 8'd5;
	localparam logic [7:0] FLAG_TRANSFER_BIT  = 8'd6;

	localparam logic [31:0] LEN_ESCAPE_HI = 32'h0000_00FF;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        in_payload;
		logic        frame_end;
		logic [2:0]  frame_kind;
		logic [15:0] property_code;
		logic [63:0] source_id;
		logic [63:0] dest_id;
		logic [31:0] body_length;
	} pfd_result_t;

endpackage

FILE: rtl/pfd_byte_if.sv
interface pfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

FILE: rtl/pfd_desc_if.sv
interface pfd_desc_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        in_payload;
	logic        frame_end;
	logic [2:0]  frame_kind;
	logic [15:0] property_code;
	logic [63:0] source_id;
	logic [63:0] dest_id;
	logic [31:0] body_length;

	modport source (output valid, output out_byte, output in_payload, output frame_end,
		output frame_kind, output property_code, output source_id, output dest_id,
		output body_length, input ready);
	modport sink (input valid, input out_byte, input in_payload, input frame_end,
		input frame_kind, input property_code, input source_id, input dest_id,
		input body_length, output ready);
endinterface

FILE: rtl/pfd_parser.sv
module pfd_parser
	import pfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	output pfd_result_t res
);

	logic [OFFSET_W-1:0] offset_q;
	logic [5:0]          hdr_len_q;
	logic [7:0]          flag_q;
	logic [15:0]         prop_q;
	logic [31:0]         len_q;
	logic                long_q;
	logic [63:0]         src_q;
	logic [63:0]         dst_q;

	logic                first;
	logic [5:0]          hdr_len;
	logic [7:0]          flag;
	logic [15:0]         prop;
	logic [31:0]         len;
	logic                long_len;
	logic [63:0]         src;
	logic [63:0]         dst;
	logic                heart;
	logic [OFFSET_W-1:0] rel;
	logic [3:0]          dh_m1;
	logic [32:0]         end_rel;
	logic                payload;
	logic                fend;

	always_comb begin
		first    = (offset_q == '0);
		hdr_len  = first ? {data_byte[3:0], 2'b00} : hdr_len_q;
		flag     = first ? 8'd0 : ((offset_q == OFFSET_W'(1)) ? data_byte : flag_q);
		prop     = first ? 16'd0 : prop_q;
		len      = first ? 32'd0 : len_q;
		long_len = first ? 1'b0 : long_q;
		src      = first ? 64'd0 : src_q;
		dst      = first ? 64'd0 : dst_q;
		payload  = 1'b0;
		fend     = 1'b0;
		dh_m1    = 4'd4;
		end_rel  = '0;

		if (offset_q >= OFFSET_W'(4) && offset_q <= OFFSET_W'(11)) begin
			src = {src[55:0], data_byte};
		end
		if (offset_q >= OFFSET_W'(12) && offset_q <= OFFSET_W'(19)) begin
			dst = {dst[55:0], data_byte};
		end

		heart = !first && flag[FLAG_HEARTBEAT_BIT[2:0]];
		rel   = offset_q - OFFSET_W'(hdr_len);

		if (heart) begin
			fend = (offset_q == OFFSET_W'(3));
		end else if (offset_q >= OFFSET_W'(hdr_len)) begin
			// data header fields are taken by position after the header
			if (rel < OFFSET_W'(2)) begin
				prop = {prop[7:0], data_byte};
			end else if (rel == OFFSET_W'(3)) begin
				len = {24'd0, data_byte};
			end else if (rel == OFFSET_W'(4)) begin
				if (len == LEN_ESCAPE_HI && data_byte == 8'd0) begin
					long_len = 1'b1;
					len      = 32'd0;
				end else begin
					len = {16'd0, len[7:0], data_byte};
				end
			end else if (long_len && rel <= OFFSET_W'(8)) begin
				len = {len[23:0], data_byte};
			end
			dh_m1   = long_len ? 4'd8 : 4'd4;
			payload = (rel > OFFSET_W'(dh_m1));
			end_rel = {1'b0, len} + 33'(dh_m1);
			fend    = (rel >= OFFSET_W'(dh_m1)) && (rel == OFFSET_W'(end_rel));
		end
	end

	always_comb begin
		res               = '0;
		res.out_byte      = data_byte;
		res.in_payload    = payload;
		res.frame_end     = fend;
		res.frame_kind    = KIND_HEARTBEAT;
		if (fend && !heart) begin
			res.property_code = prop;
			res.body_length   = len;
			priority if (flag[FLAG_TRANSFER_BIT[2:0]]) begin
				res.frame_kind = KIND_TRANSFER;
				res.source_id  = src;
				res.dest_id    = dst;
			end else if (prop == PROP_CHAT) begin
				res.frame_kind = KIND_CHAT;
			end else if (prop == PROP_LOGIN) begin
				res.frame_kind = KIND_LOGIN;
			end else if (prop == PROP_CHECK) begin
				res.frame_kind = KIND_CHECK;
			end else begin
				res.frame_kind = KIND_UNKNOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (step) begin
			offset_q <= fend ? '0 : offset_q + OFFSET_W'(1);
		end
	end

	// field registers are all rewritten on the first byte of a frame
	always_ff @(posedge clk) begin
		if (step) begin
			hdr_len_q <= hdr_len;
			flag_q    <= flag;
			prop_q    <= prop;
			len_q     <= len;
			long_q    <= long_len;
			src_q     <= src;
			dst_q     <= dst;
		end
	end

endmodule

FILE: rtl/push_frame_deframer_top.sv
// Frame deframer for a byte stream.
// Channel raw carries one stream byte per request (data_byte). Channel desc
// returns one request per byte: the byte itself, whether it lies in the
// payload, and on the last byte of a frame the end flag with the frame
// descriptor (kind, property id, transfer ids, body length); the descriptor
// fields are zero on every other byte.
// A byte is registered in the input register on acceptance, classified by the
// parser combinationally and placed in the output register, from which its
// result is offered to the receiver.
// One byte is accepted per cycle while the receiver does not stall; the parser
// updates its offset counter and field registers once per byte.
// Reset clears both pipeline stages and the frame offset, so the first byte
// after reset is taken as byte 0 of a frame.
// When the receiver stalls, the output register holds its result and the
// input register holds one more byte; raw.ready drops only when both are
// full, and nothing is lost or repeated.
module push_frame_deframer_top
	import pfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pfd_byte_if.sink   raw,
	pfd_desc_if.source desc
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	pfd_result_t res_s2;
	pfd_result_t res;
	logic        advance;

	assign advance   = !valid_s2 || desc.ready;
	assign raw.ready = !valid_s1 || advance;

	pfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance && valid_s1),
		.data_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (raw.ready) begin
				valid_s1 <= raw.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1 <= raw.data_byte;
		end
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign desc.valid         = valid_s2;
	assign desc.out_byte      = res_s2.out_byte;
	assign desc.in_payload    = res_s2.in_payload;
	assign desc.frame_end     = res_s2.frame_end;
	assign desc.frame_kind    = res_s2.frame_kind;
	assign desc.property_code = res_s2.property_code;
	assign desc.source_id     = res_s2.source_id;
	assign desc.dest_id       = res_s2.dest_id;
	assign desc.body_length   = res_s2.body_length;

`ifndef ASSERT_OFF
	// descriptor fields stay zero away from a frame end
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.frame_end |-> res_s2.frame_kind == KIND_HEARTBEAT
			&& res_s2.property_code == '0 && res_s2.body_length == '0
			&& res_s2.source_id == '0 && res_s2.dest_id == '0)
		else $error("descriptor set on a byte that is not a frame end");

	a_heartbeat_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_end && res_s2.frame_kind == KIND_HEARTBEAT
			|-> res_s2.property_code == '0 && res_s2.body_length == '0
			&& !res_s2.in_payload)
		else $error("heartbeat descriptor carries data header fields");

	a_ids_transfer_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.frame_kind != KIND_TRANSFER
			|-> res_s2.source_id == '0 && res_s2.dest_id == '0)
		else $error("ids reported on a frame that is not a transfer");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost its byte while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.frame_kind <= KIND_UNKNOWN)
		else $error("frame kind out of range");
`endif

endmodule
